/* src/wbps_pkg.sv */
// shared types and constants for the wildcard byte pattern scanner
package wbps_pkg;

  // field widths
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PAT_SLOTS     = 32;
  localparam int unsigned PAT_IDX_W     = 5;
  localparam int unsigned PAT_LEN_W     = 6;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned BYTES_PER_REG = 8;

  // parameter defaults
  localparam int unsigned MAX_PATTERN_DEF   = 32;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LENGTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_OFFSET   = 3'd6;

  // input word
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_region;
  } in_word_t;

  // result word
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_word_t;

  // configuration register file contents
  typedef struct packed {
    logic [PAT_SLOTS-1:0][BYTE_W-1:0] pattern_bytes;
    logic [PAT_SLOTS-1:0]             wildcard_mask;
    logic [PAT_LEN_W-1:0]             pattern_length;
    logic [ADDR_W-1:0]                result_offset;
  } cfg_regs_t;

endpackage

/* src/wbps_cfg_regs.sv */
// configuration register file of the pattern scanner
module wbps_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output wbps_pkg::cfg_regs_t                cfg_o
);

  wbps_pkg::cfg_regs_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes  <= '0;
      cfg_q.wildcard_mask  <= '0;
      cfg_q.pattern_length <= wbps_pkg::PAT_LEN_W'(1);
      cfg_q.result_offset  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wbps_pkg::CFG_PAT_LOW:      cfg_q.pattern_bytes[7:0]   <= cfg_data_i;
        wbps_pkg::CFG_PAT_MID_LOW:  cfg_q.pattern_bytes[15:8]  <= cfg_data_i;
        wbps_pkg::CFG_PAT_MID_HIGH: cfg_q.pattern_bytes[23:16] <= cfg_data_i;
        wbps_pkg::CFG_PAT_HIGH:     cfg_q.pattern_bytes[31:24] <= cfg_data_i;
        wbps_pkg::CFG_WILDCARD: begin
          cfg_q.wildcard_mask <= cfg_data_i[wbps_pkg::PAT_SLOTS-1:0];
        end
        wbps_pkg::CFG_PAT_LENGTH: begin
          cfg_q.pattern_length <= cfg_data_i[wbps_pkg::PAT_LEN_W-1:0];
        end
        wbps_pkg::CFG_RES_OFFSET: begin
          cfg_q.result_offset <= cfg_data_i[wbps_pkg::ADDR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/wbps_match_core.sv */
// sliding byte window, masked compare and scan state
module wbps_match_core #(
  parameter int unsigned MAX_PATTERN   = wbps_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = wbps_pkg::POSITION_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  wbps_pkg::in_word_t   word_i,
  input  wbps_pkg::cfg_regs_t  cfg_i,
  output logic                 res_valid_o,
  output wbps_pkg::out_word_t  res_o
);

  localparam int unsigned PAT_CAP = (MAX_PATTERN < wbps_pkg::PAT_SLOTS) ?
                                    MAX_PATTERN : wbps_pkg::PAT_SLOTS;
  localparam int unsigned FILL_W  = $clog2(PAT_CAP + 1);
  localparam int unsigned SUM_W   = (POSITION_BITS > wbps_pkg::ADDR_W) ?
                                    POSITION_BITS : wbps_pkg::ADDR_W;
  localparam int unsigned LW      = wbps_pkg::PAT_LEN_W;

  logic [PAT_CAP-1:0][wbps_pkg::BYTE_W-1:0] window_q;
  logic [PAT_CAP-1:0][wbps_pkg::BYTE_W-1:0] window_d;
  logic [FILL_W-1:0]                        fill_q;
  logic [FILL_W-1:0]                        fill_d;
  logic [POSITION_BITS-1:0]                 pos_q;
  logic                                     finished_q;

  logic [LW-1:0]                            eff_len;
  logic [PAT_CAP-1:0][wbps_pkg::PAT_IDX_W-1:0] pat_idx;
  logic [PAT_CAP-1:0]                       hit;
  logic                                     fill_ok;
  logic                                     match;
  logic                                     active;
  logic [POSITION_BITS-1:0]                 start_pos;
  logic [SUM_W-1:0]                         addr_sum;

  // clamp the configured length to 1..PAT_CAP
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      eff_len = LW'(1);
    end else if (cfg_i.pattern_length > LW'(PAT_CAP)) begin
      eff_len = LW'(PAT_CAP);
    end else begin
      eff_len = cfg_i.pattern_length;
    end
  end

  // window with the new byte shifted in, newest at slot 0
  always_comb begin
    window_d[0] = word_i.data_byte;
    for (int j = 1; j < PAT_CAP; j++) begin
      window_d[j] = window_q[j-1];
    end
  end

  // saturating count of valid window bytes
  assign fill_d = (fill_q == FILL_W'(PAT_CAP)) ? fill_q : fill_q + FILL_W'(1);

  // each window slot against the pattern byte aligned to it
  always_comb begin
    for (int j = 0; j < PAT_CAP; j++) begin
      pat_idx[j] = wbps_pkg::PAT_IDX_W'(eff_len - LW'(1) - LW'(j));
      hit[j]     = (LW'(j) >= eff_len) ||
                   cfg_i.wildcard_mask[pat_idx[j]] ||
                   (window_d[j] == cfg_i.pattern_bytes[pat_idx[j]]);
    end
  end

  assign fill_ok = (7'(fill_d) >= 7'(eff_len));
  assign match   = fill_ok && (&hit);
  assign active  = !finished_q;

  // start of the match and the reported address
  assign start_pos = pos_q - POSITION_BITS'(eff_len) + POSITION_BITS'(1);
  assign addr_sum  = SUM_W'(start_pos) + SUM_W'(cfg_i.result_offset);

  // result of the word being stepped
  always_comb begin
    res_valid_o         = active && (match || word_i.end_of_region);
    res_o.found         = match;
    res_o.match_address = match ? addr_sum[wbps_pkg::ADDR_W-1:0] : '0;
  end

  // scan state: end of region clears, a match freezes until then
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pos_q      <= '0;
      finished_q <= 1'b0;
    end else if (step_i) begin
      if (word_i.end_of_region) begin
        fill_q     <= '0;
        pos_q      <= '0;
        finished_q <= 1'b0;
      end else if (active) begin
        fill_q     <= fill_d;
        pos_q      <= pos_q + POSITION_BITS'(1);
        finished_q <= match;
      end
    end
  end

  // window bytes, gated by the fill count so they need no reset
  always_ff @(posedge clk_i) begin
    if (step_i && active && !word_i.end_of_region) begin
      window_q <= window_d;
    end
  end

endmodule

/* src/wildcard_byte_pattern_scanner.sv */
// Wildcard byte pattern scanner, top level.
// Bytes of a region arrive on the input channel (in_valid_i, in_stall_o,
// in_word_i), one byte per word, the last one marked by end_of_region.
// The block looks for the first occurrence of the configured pattern, in
// which any byte may be a wildcard. A match gives one result word with
// found=1 and the start position plus result_offset; a region ending with
// no match gives found=0 and address zero; other bytes give no result.
// After a match the rest of the region is dropped silently.
// The user must write registers through cfg_we_i / cfg_index_i /
// cfg_data_i only while the block is idle; the block does not enforce
// it. Unknown indexes are ignored. The byte is accepted into the input
// register, then the window compare loads the output register.
// Throughput is one byte per cycle while no result waits on out_stall_i;
// the full window compare sits between those two registers.
// Reset clears the scan state and loads the register reset values.
// When out_stall_i holds a waiting result, the byte in the input register
// waits and in_stall_o rises; no word is lost.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN   = wbps_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = wbps_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wbps_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wbps_pkg::out_word_t             out_word_o,
  input  logic                            cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  wbps_pkg::cfg_regs_t cfg;
  wbps_pkg::in_word_t  in_word_q;
  logic                in_valid_q;
  wbps_pkg::out_word_t out_word_q;
  logic                out_valid_q;
  wbps_pkg::out_word_t res;
  logic                res_valid;
  logic                in_accept;
  logic                advance;

  wbps_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake: the held word moves on when the output slot is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  wbps_match_core #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_match_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .word_i      (in_word_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTH
  // a region end without a match carries a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.found) |-> (out_word_o.match_address == '0))
    else $error("not-found result with nonzero address");

  // a result produced by the compare shows up in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid) |=> out_valid_o)
    else $error("compare result lost");

  // input is only held off while a word waits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o))
    else $error("input stalled with free stages");
`endif

endmodule

/* tb/wbps_scan_checker.sv */
// checker for the wildcard byte pattern scanner: predicts scan outcomes and compares result words
`timescale 1ns / 1ps

module wbps_scan_checker
  import wbps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_word_t             out_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           outcomes_due_o,
  output int unsigned           mismatches_o
);

  // predictor copy of the registers and the scan state
  cfg_regs_t         cfg;
  logic [BYTE_W-1:0] window [PAT_SLOTS];
  logic [ADDR_W-1:0] bytes_seen;
  int unsigned       window_fill;
  logic              search_done;
  out_word_t         outcome_q [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches_o++;
  endtask

  task automatic clear_scan();
    for (int i = 0; i < PAT_SLOTS; i++) begin
      window[i] = '0;
    end
    bytes_seen  = '0;
    window_fill = 0;
    search_done = 1'b0;
  endtask

  // register write, unknown indexes are dropped
  task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PAT_LOW, CFG_PAT_MID_LOW, CFG_PAT_MID_HIGH, CFG_PAT_HIGH: begin
        for (int j = 0; j < BYTES_PER_REG; j++) begin
          cfg.pattern_bytes[int'(idx) * BYTES_PER_REG + j] = data[j*BYTE_W +: BYTE_W];
        end
      end
      CFG_WILDCARD:   cfg.wildcard_mask  = data[PAT_SLOTS-1:0];
      CFG_PAT_LENGTH: cfg.pattern_length = data[PAT_LEN_W-1:0];
      CFG_RES_OFFSET: cfg.result_offset  = data[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  // shift one byte into the window and work out the outcome it causes
  task automatic scan_byte(input in_word_t w);
    int unsigned       len;
    logic [ADDR_W-1:0] pos;
    logic              hit;
    out_word_t         res;
    if (!search_done) begin
      len = cfg.pattern_length;
      if (len == 0) len = 1;
      if (len > PAT_SLOTS) len = PAT_SLOTS;
      pos = bytes_seen;
      for (int i = PAT_SLOTS - 1; i > 0; i--) begin
        window[i] = window[i-1];
      end
      window[0] = w.data_byte;
      if (window_fill < PAT_SLOTS) window_fill++;
      bytes_seen = bytes_seen + 1'b1;
      // oldest window byte lines up with pattern byte 0
      hit = (window_fill >= len);
      for (int k = 0; k < len; k++) begin
        if (!cfg.wildcard_mask[k] && window[len-1-k] != cfg.pattern_bytes[k]) hit = 1'b0;
      end
      if (hit) begin
        res.found         = 1'b1;
        res.match_address = pos - ADDR_W'(len) + 1'b1 + cfg.result_offset;
        outcome_q.push_back(res);
        search_done = 1'b1;
      end else if (w.end_of_region) begin
        res = '0;
        outcome_q.push_back(res);
      end
    end
    if (w.end_of_region) clear_scan();
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch($sformatf("result word with no outcome due: found=%0b address=%h",
                                got.found, got.match_address));
    end else begin
      want = outcome_q.pop_front();
      if (got.found !== want.found)
        report_mismatch($sformatf("found: got %0b, want %0b", got.found, want.found));
      if (got.match_address !== want.match_address)
        report_mismatch($sformatf("match_address: got %h, want %h",
                                  got.match_address, want.match_address));
    end
  endtask

  // results are checked before the same-edge input is scanned
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg                = '0;
      cfg.pattern_length = PAT_LEN_W'(1);
      clear_scan();
      outcome_q.delete();
      mismatches_o   = 0;
      outcomes_due_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_word_i);
      if (in_valid_i && !in_stall_i) scan_byte(in_word_i);
      if (cfg_we_i) load_register(cfg_index_i, cfg_data_i);
      outcomes_due_o <= outcome_q.size();
    end
  end

endmodule

/* tb/tb_wildcard_byte_pattern_scanner.sv */
// testbench top for the wildcard byte pattern scanner: stimulus, stall control and verdict
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner;
  import wbps_pkg::*;

  localparam int unsigned HALF_PERIOD  = 6;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_WORDS  = 165;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned words_sent;
  int unsigned outcomes_due;
  int unsigned mismatches;

  // stimulus copy of the pattern, used to build matching regions
  logic [BYTE_W-1:0]    pat_bytes [PAT_SLOTS];
  logic [PAT_SLOTS-1:0] wild;
  int unsigned          pat_len;

  wildcard_byte_pattern_scanner uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  wbps_scan_checker scan_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_word_i      (in_word),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_word_i     (out_word),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .outcomes_due_o (outcomes_due),
    .mismatches_o   (mismatches)
  );

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // receiver side: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no word or write accepted
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // offer one word, with random gaps ahead of it, and wait for acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid              <= 1'b1;
    in_word.data_byte     <= b;
    in_word.end_of_region <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // drop valid, wait for every outcome, then let the pipeline run dry
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcomes_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // filler leans on pattern bytes so partial and overlapping candidates show up
  function automatic logic [BYTE_W-1:0] filler_byte();
    if ($urandom_range(1) == 1) return pat_bytes[$urandom_range(pat_len - 1)];
    return BYTE_W'($urandom);
  endfunction

  // one region: full pattern, broken prefix or plain noise, with random lead and tail
  task automatic send_region();
    int unsigned kind;
    int unsigned lead;
    int unsigned tail;
    int unsigned cut;
    in_word_t    w;
    in_word_t    region_q [$];
    kind = $urandom_range(9);
    lead = $urandom_range(12);
    tail = $urandom_range(6);
    w.end_of_region = 1'b0;
    for (int k = 0; k < lead; k++) begin
      w.data_byte = filler_byte();
      region_q.push_back(w);
    end
    if (kind <= 5) begin
      for (int k = 0; k < pat_len; k++) begin
        w.data_byte = wild[k] ? BYTE_W'($urandom) : pat_bytes[k];
        region_q.push_back(w);
      end
    end else if (kind <= 7) begin
      cut = $urandom_range(pat_len - 1);
      for (int k = 0; k < cut; k++) begin
        w.data_byte = pat_bytes[k];
        region_q.push_back(w);
      end
      w.data_byte = BYTE_W'($urandom);
      region_q.push_back(w);
    end
    for (int k = 0; k < tail; k++) begin
      w.data_byte = filler_byte();
      region_q.push_back(w);
    end
    if (region_q.size() == 0) begin
      w.data_byte = BYTE_W'($urandom);
      region_q.push_back(w);
    end
    region_q[region_q.size() - 1].end_of_region = 1'b1;
    foreach (region_q[i]) send_byte(region_q[i].data_byte, region_q[i].end_of_region);
  endtask

  // one register setting per phase, extremes included
  task automatic configure(input int s);
    logic [CFG_DATA_W-1:0] regs [4];
    logic [31:0]           mask_v;
    logic [31:0]           off_v;
    int unsigned           len_v;
    for (int r = 0; r < 4; r++) begin
      regs[r] = (s == 4) ? 64'h0 : (s == 6) ? {64{1'b1}} : {$urandom, $urandom};
    end
    off_v = $urandom;
    case (s)
      0: begin mask_v = '0;                               len_v = 4; end
      1: begin mask_v = $urandom & $urandom;              len_v = $urandom_range(8, 1); end
      2: begin mask_v = $urandom;                         len_v = 32; off_v = 32'hFFFF_FFF0; end
      3: begin mask_v = $urandom | $urandom;              len_v = 63; end
      4: begin mask_v = '0;                               len_v = $urandom_range(12, 1); end
      5: begin mask_v = $urandom & $urandom & $urandom;   len_v = $urandom_range(3, 1); end
      default: begin mask_v = '0;                         len_v = 5; off_v = '0; end
    endcase
    write_reg(CFG_PAT_LOW,      regs[0]);
    write_reg(CFG_PAT_MID_LOW,  regs[1]);
    write_reg(CFG_PAT_MID_HIGH, regs[2]);
    write_reg(CFG_PAT_HIGH,     regs[3]);
    write_reg(CFG_WILDCARD,     {$urandom, mask_v});
    write_reg(CFG_PAT_LENGTH,   {$urandom, 26'($urandom), 6'(len_v)});
    write_reg(CFG_RES_OFFSET,   {$urandom, off_v});
    for (int k = 0; k < PAT_SLOTS; k++) begin
      pat_bytes[k] = regs[k / BYTES_PER_REG][(k % BYTES_PER_REG) * BYTE_W +: BYTE_W];
    end
    wild    = mask_v;
    pat_len = (len_v == 0) ? 1 : (len_v > PAT_SLOTS) ? PAT_SLOTS : len_v;
  endtask

  initial begin
    int unsigned first_word;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    words_sent    = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset pattern is a single zero byte: match, ignored bytes, silent clear,
    // region end with no match, match on the last byte
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    settle();

    // zero length acts as one, offset wraps the address, unknown index dropped
    write_reg(CFG_PAT_LOW, 64'h0123_4567_89AB_CDAB);
    write_reg(CFG_PAT_LENGTH, {$urandom, $urandom} & ~64'h3F);
    write_reg(CFG_RES_OFFSET, {$urandom, 32'hFFFF_FFFF});
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    send_byte(8'h12, 1'b0);
    send_byte(8'hAB, 1'b1);
    settle();

    // all wildcards, length three: short region misses, full one matches on its end
    write_reg(CFG_PAT_LENGTH, 64'd3);
    write_reg(CFG_WILDCARD, {64{1'b1}});
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b1);
    settle();

    // random regions over several settings and idling mixes
    for (int s = 0; s < PHASES; s++) begin
      @(posedge clk);
      send_idle_pct = (s < 2) ? 11 : (s < 4) ? 51 : 0;
      recv_idle_pct = (s < 2) ? 51 : (s < 4) ? 11 : 0;
      configure(s);
      if (s == 5) begin
        // receiver holds off while words keep coming, so the block backs up
        @(posedge clk);
        hold_left = HOLD_CYCLES;
      end
      first_word = words_sent;
      while (words_sent - first_word < PHASE_WORDS) send_region();
      settle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
